FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same, but the property is checked in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

FILE: rtl/core/hpq_pkg.sv
package hpq_pkg;

	localparam int DATA_W       = 32;
	localparam int COUNT_OUT_W  = 7;
	localparam int CAPACITY_DEF = 127;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                     v;
		logic signed [DATA_W-1:0] d;
	} slot_t;

	// what a cell hands to its right-hand neighbor
	typedef struct packed {
		slot_t slot;
		logic  gt;   // the inserted value belongs at or before this cell
	} link_t;

endpackage

FILE: rtl/core/hpq_cell.sv
module hpq_cell
	import hpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ins_en,
	input  logic                     del_en,
	input  logic signed [DATA_W-1:0] ins_value,
	input  link_t                    left,
	input  slot_t                    right,
	output link_t                    link,
	output slot_t                    cur,
	output slot_t                    nxt
);

	logic                     v_q;
	logic signed [DATA_W-1:0] d_q;
	logic                     gt;

	assign cur  = '{v: v_q, d: d_q};
	// cells are kept in descending order, empty cells at the tail
	assign gt   = !v_q || (ins_value > d_q);
	assign link = '{slot: cur, gt: gt};

	always_comb begin
		nxt = cur;
		if (ins_en) begin
			if (left.gt) begin
				nxt = left.slot;
			end else if (gt) begin
				nxt = '{v: 1'b1, d: ins_value};
			end
		end else if (del_en) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= nxt.v;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt.d;
	end

endmodule

FILE: rtl/core/max_heap_priority_queue.sv
// Max priority queue of signed 32-bit values.
// Input channel (in_valid/in_ready): req_type 0 inserts value, 1 removes the
// maximum. Output channel (out_valid/out_ready): one result per request with
// status (done, full, empty), the maximum after the request, top_valid and
// the count (low 7 bits).
// Storage is a row of CAPACITY cells kept in descending order. Every cell
// compares the broadcast insert value with its own entry in the same cycle
// and either keeps, takes the new value or takes its left neighbor's entry;
// a remove shifts every cell one place toward the head.
// Latency: the result is registered at the edge that accepts the request and
// shows on the next cycle. Throughput: one request per cycle, set by the
// single compare-and-shift step across the cell row.
// A waiting result holds off the next request only while out_ready is low; a
// new request is taken in the cycle the result leaves. If the receiver stalls,
// in_ready drops until the result is taken.
// Reset empties the queue (all cell valid bits clear, count zero); no
// clearing pass is needed.
`include "assert_macros.svh"

module max_heap_priority_queue
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] top_value,
	output logic                     top_valid,
	output logic [COUNT_OUT_W-1:0]   count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic          acc;
	logic          full;
	logic          empty;
	logic          ins_en;
	logic          del_en;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	status_t       st;

	link_t lnk [CAPACITY+1];
	slot_t cur [CAPACITY+1];
	slot_t nxt [CAPACITY];

	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] top_value_q;
	logic                     top_valid_q;
	logic [COUNT_OUT_W-1:0]   count_out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign full     = count_q == CW'(CAPACITY);
	assign empty    = count_q == '0;
	assign ins_en   = acc && (req_type == REQ_INSERT) && !full;
	assign del_en   = acc && (req_type == REQ_REMOVE) && !empty;

	always_comb begin
		st        = ST_DONE;
		count_nxt = count_q;
		if (req_type == REQ_INSERT) begin
			if (full) begin
				st = ST_FULL;
			end else begin
				count_nxt = CW'(count_q + 1'b1);
			end
		end else begin
			if (empty) begin
				st = ST_EMPTY;
			end else begin
				count_nxt = CW'(count_q - 1'b1);
			end
		end
	end

	assign lnk[0]          = '{slot: '{v: 1'b0, d: '0}, gt: 1'b0};
	assign cur[CAPACITY]   = '{v: 1'b0, d: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		hpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins_en   (ins_en),
			.del_en   (del_en),
			.ins_value(value),
			.left     (lnk[i]),
			.right    (cur[i+1]),
			.link     (lnk[i+1]),
			.cur      (cur[i]),
			.nxt      (nxt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= st;
			top_value_q <= nxt[0].v ? nxt[0].d : '0;
			top_valid_q <= nxt[0].v;
			count_out_q <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_value_q;
	assign top_valid = top_valid_q;
	assign count     = count_out_q;

	`ASSERT_CLK(a_head_matches_count, clk, arst_n,
		cur[0].v == (count_q != '0), "head cell valid disagrees with count")
	`ASSERT_CLK(a_top_valid_count, clk, arst_n,
		!out_valid_q || (top_valid_q == (count_q != '0)),
		"result top_valid disagrees with count")
	`ASSERT_NEXT(a_full_holds, clk, arst_n,
		acc && (req_type == REQ_INSERT) && full, count_q == $past(count_q),
		"rejected insert changed the count")
	`ASSERT_CLK(a_empty_result, clk, arst_n,
		!(out_valid_q && status_q == ST_EMPTY) || !top_valid_q,
		"empty rejection with a valid top")

endmodule

FILE: bench/tb_max_heap_priority_queue.sv
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;
	import hpq_pkg::*;

	localparam int HEAP_DEPTH = CAPACITY_DEF;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef struct {
		status_t                  st;
		logic signed [DATA_W-1:0] top;
		logic                     vld;
		logic [COUNT_OUT_W-1:0]   cnt;
	} heap_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     req_type = REQ_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] top_value;
	logic                     top_valid;
	logic [COUNT_OUT_W-1:0]   count;

	// model of the queue contents as a one-based binary heap
	logic signed [DATA_W-1:0] pq_slots [1:HEAP_DEPTH];
	int unsigned              pq_size = 0;
	heap_result_t             pending_results [$];

	int error_cnt = 0;
	int n_inserts = 0;
	int n_removes = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_checked = 0;
	int deepest = 0;
	int idle_pct = 30;
	int long_hold_req = 0;

	max_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.top_value (top_value),
		.top_valid (top_valid),
		.count     (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return S32_MAX;
			1: return S32_MIN;
			2, 3: return $signed($urandom_range(0, 15)) - 8;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic signed [DATA_W-1:0] t;
		t = pq_slots[a];
		pq_slots[a] = pq_slots[b];
		pq_slots[b] = t;
	endfunction

	function automatic heap_result_t apply_request(input logic rt,
			input logic signed [DATA_W-1:0] v);
		heap_result_t r;
		int unsigned  pos;
		int unsigned  best;
		int unsigned  lc;
		r.st = ST_DONE;
		if (rt == REQ_INSERT) begin
			if (pq_size >= HEAP_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				pq_size++;
				pos = pq_size;
				pq_slots[pos] = v;
				while (pos > 1 && pq_slots[pos / 2] < pq_slots[pos]) begin
					swap_slots(pos, pos / 2);
					pos = pos / 2;
				end
			end
		end else if (pq_size == 0) begin
			r.st = ST_EMPTY;
		end else begin
			pq_slots[1] = pq_slots[pq_size];
			pq_size--;
			pos = 1;
			while (pos < pq_size) begin
				best = pos;
				lc = 2 * pos;
				// left child wins ties; right must be strictly larger
				if (lc <= pq_size && pq_slots[best] < pq_slots[lc])
					best = lc;
				if (lc + 1 <= pq_size && pq_slots[best] < pq_slots[lc + 1])
					best = lc + 1;
				if (best == pos)
					break;
				swap_slots(best, pos);
				pos = best;
			end
		end
		r.vld = (pq_size > 0);
		r.top = r.vld ? pq_slots[1] : '0;
		r.cnt = pq_size[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send_req(input logic rt, input logic signed [DATA_W-1:0] v);
		int           gap;
		heap_result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		value <= v;
		do @(posedge clk); while (!in_ready);
		r = apply_request(rt, v);
		pending_results.push_back(r);
		if (rt == REQ_INSERT)
			n_inserts++;
		else
			n_removes++;
		if (r.st == ST_FULL)
			n_full++;
		if (r.st == ST_EMPTY)
			n_empty++;
		if (pq_size > deepest)
			deepest = pq_size;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_one_result();
		heap_result_t e;
		if (pending_results.size() == 0) begin
			$error("result with no request outstanding: status %0d top %0d count %0d",
				status, top_value, count);
			error_cnt++;
			return;
		end
		e = pending_results.pop_front();
		n_checked++;
		if (status !== e.st) begin
			$error("status: expected %0d, actual %0d", e.st, status);
			error_cnt++;
		end
		if (top_value !== e.top) begin
			$error("top_value: expected %0d, actual %0d", e.top, top_value);
			error_cnt++;
		end
		if (top_valid !== e.vld) begin
			$error("top_valid: expected %0d, actual %0d", e.vld, top_valid);
			error_cnt++;
		end
		if (count !== e.cnt) begin
			$error("count: expected %0d, actual %0d", e.cnt, count);
			error_cnt++;
		end
	endtask

	// result side: checks each accepted result and drives out_ready
	initial begin : result_sink
		int stall_left;
		int gap_left;
		stall_left = 0;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && out_ready)
					check_one_result();
				if (long_hold_req != 0) begin
					stall_left = long_hold_req;
					long_hold_req = 0;
				end
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					out_ready <= 1'b0;
				end else begin
					gap_left = pick_gap();
					if (gap_left > 0) begin
						gap_left--;
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			end
		end
	end

	task automatic test_corner_values();
		send_req(REQ_REMOVE, 32'sh1234_5678);   // empty queue
		send_req(REQ_INSERT, 0);
		send_req(REQ_INSERT, S32_MIN);
		send_req(REQ_INSERT, S32_MAX);
		send_req(REQ_INSERT, -1);
		send_req(REQ_INSERT, S32_MAX);          // duplicate maximum
		send_req(REQ_INSERT, 1);
		send_req(REQ_INSERT, -1);
		send_req(REQ_INSERT, 32'sh5555_5555);
		send_req(REQ_INSERT, 32'shaaaa_aaaa);
		repeat (9)
			send_req(REQ_REMOVE, $signed($urandom));
		send_req(REQ_REMOVE, S32_MIN);          // empty again
		send_req(REQ_INSERT, S32_MIN);
		send_req(REQ_REMOVE, 0);
		wait_results_drained();
	endtask

	task automatic test_fill_and_drain();
		while (pq_size < HEAP_DEPTH) begin
			// an occasional remove keeps the sift paths varied on the way up
			if ($urandom_range(0, 9) == 0)
				send_req(REQ_REMOVE, $signed($urandom));
			else
				send_req(REQ_INSERT, pick_value());
		end
		repeat (3)
			send_req(REQ_INSERT, pick_value());
		send_req(REQ_REMOVE, 0);
		send_req(REQ_INSERT, S32_MAX);
		send_req(REQ_INSERT, S32_MIN);       // full again
		while (pq_size > 0)
			send_req(REQ_REMOVE, $signed($urandom));
		repeat (2)
			send_req(REQ_REMOVE, $signed($urandom));
		wait_results_drained();
	endtask

	task automatic test_random_mix(input int n_req);
		logic rt;
		repeat (n_req) begin
			// lean toward inserts so the heap grows to a useful depth
			rt = ($urandom_range(0, 99) < 58) ? REQ_INSERT : REQ_REMOVE;
			send_req(rt, pick_value());
		end
	endtask

	task automatic test_output_stall();
		int saved;
		saved = idle_pct;
		idle_pct = 0;
		long_hold_req = 300;
		repeat (12)
			send_req($urandom_range(0, 3) == 0 ? REQ_REMOVE : REQ_INSERT, pick_value());
		idle_pct = saved;
		wait_results_drained();
	endtask

	task automatic test_burst();
		int saved;
		saved = idle_pct;
		idle_pct = 0;
		test_random_mix(40);
		idle_pct = saved;
		wait_results_drained();
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_fill_and_drain();
		test_random_mix(60);
		wait_results_drained();
		test_output_stall();
		test_burst();
		test_random_mix(30);
		wait_results_drained();
		repeat (5) @(posedge clk);
		$display("Checked %0d results: %0d inserts, %0d removes, deepest fill %0d of %0d.",
			n_checked, n_inserts, n_removes, deepest, HEAP_DEPTH);
		$display("Requests refused: %0d on a full queue, %0d on an empty one.",
			n_full, n_empty);
		if (error_cnt == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/hpq_pkg.sv
rtl/core/hpq_cell.sv
rtl/core/max_heap_priority_queue.sv
bench/tb_max_heap_priority_queue.sv
